// File: design/u16v_pkg.sv
// ----------------------------------------------------------------------------
// u16v_pkg: shared types and constants of the utf-16 stream validator
// byte order modes, result status codes, unit phases and the result payload
// ----------------------------------------------------------------------------
package u16v_pkg;

   localparam logic [1:0] MODE_DETECT = 2'd0;
   localparam logic [1:0] MODE_LITTLE = 2'd1;
   localparam logic [1:0] MODE_BIG    = 2'd2;

   localparam logic [1:0] STATUS_OK        = 2'd0;
   localparam logic [1:0] STATUS_TRUNCATED = 2'd1;
   localparam logic [1:0] STATUS_NO_LOW    = 2'd2;

   localparam logic [15:0] BOM_NATIVE   = 16'hFEFF;
   localparam logic [15:0] BOM_SWAPPED  = 16'hFFFE;
   localparam logic [15:0] REPLACEMENT  = 16'hFFFD;

   localparam logic [5:0] HIGH_SURR_TAG = 6'b110110;
   localparam logic [5:0] LOW_SURR_TAG  = 6'b110111;

   typedef enum logic [1:0] {
      PHASE_START,
      PHASE_ONE_BYTE,
      PHASE_HIGH,
      PHASE_HIGH_BYTE
   } phase_type;

   typedef struct packed {
      logic [15:0] first_unit;
      logic [15:0] second_unit;
      logic [1:0]  unit_count;
      logic [1:0]  status;
      logic        detected_little;
      logic        end_of_run;
   } result_type;

endpackage

// File: design/u16v_req_if.sv
// ----------------------------------------------------------------------------
// u16v_req_if: byte channel into the validator
// one raw stream byte per beat with a flag on the final byte
// ----------------------------------------------------------------------------
interface u16v_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] data_byte;
   logic       last_byte;

   modport source (output valid, output data_byte, output last_byte, input ready);
   modport sink   (input valid, input data_byte, input last_byte, output ready);
endinterface

// File: design/u16v_rsp_if.sv
// ----------------------------------------------------------------------------
// u16v_rsp_if: result channel out of the validator
// rebuilt code units, status and stream flags per beat
// ----------------------------------------------------------------------------
interface u16v_rsp_if;
   logic        valid;
   logic        ready;
   logic [15:0] first_unit;
   logic [15:0] second_unit;
   logic [1:0]  unit_count;
   logic [1:0]  status;
   logic        detected_little;
   logic        end_of_run;

   modport source (output valid, output first_unit, output second_unit,
                   output unit_count, output status, output detected_little,
                   output end_of_run, input ready);
   modport sink   (input valid, input first_unit, input second_unit,
                   input unit_count, input status, input detected_little,
                   input end_of_run, output ready);
endinterface

// File: design/utf16_stream_validator.sv
// ----------------------------------------------------------------------------
// utf16_stream_validator: utf-16 byte stream checker and unit rebuilder
// a result is registered into the result queue before it appears on rsp_bus
// throughput: one byte per cycle while the result queue is not full
// a two-entry result queue keeps bytes flowing while a result waits
// reset: synchronous, clears phase, byte order, queue and mode register
// ----------------------------------------------------------------------------
module utf16_stream_validator (
   input  logic              clock,
   input  logic              reset,
   input  logic              csr_write_enable,
   input  logic [1:0]        csr_write_data,
   u16v_req_if.sink          req_bus,
   u16v_rsp_if.source        rsp_bus
);
   import u16v_pkg::*;

   logic [1:0]  mode_ff;
   phase_type   phase_ff, phase_in;
   logic [7:0]  held_byte_ff, held_byte_in;
   logic [15:0] held_high_ff, held_high_in;
   logic        little_ff, little_in;
   logic        start_ff, start_in;

   result_type  slot0_ff, slot0_in;
   result_type  slot1_ff, slot1_in;
   logic [1:0]  count_ff, count_in;

   result_type  res;
   logic        produce;
   logic        accept;
   logic        pop;
   logic        detect;
   logic        little_cur;
   logic [15:0] unit;
   logic        dropped;
   logic [1:0]  wr_pos;

   assign req_bus.ready = (count_ff != 2'd2);
   assign accept        = req_bus.valid && req_bus.ready;
   assign pop           = (count_ff != 2'd0) && rsp_bus.ready;

   assign detect     = (mode_ff != MODE_LITTLE) && (mode_ff != MODE_BIG);
   assign little_cur = (start_ff && phase_ff == PHASE_START) ? (mode_ff == MODE_LITTLE)
                                                             : little_ff;
   assign unit = little_cur ? {req_bus.data_byte, held_byte_ff}
                            : {held_byte_ff, req_bus.data_byte};

   // byte phase and unit decode
   always_comb begin
      phase_in     = phase_ff;
      held_byte_in = held_byte_ff;
      held_high_in = held_high_ff;
      little_in    = little_ff;
      start_in     = start_ff;
      produce      = 1'b0;
      dropped      = 1'b0;
      res          = '0;
      if (accept) begin
         little_in = little_cur;
         case (phase_ff)
            PHASE_START: begin
               held_byte_in = req_bus.data_byte;
               phase_in     = PHASE_ONE_BYTE;
            end
            PHASE_ONE_BYTE: begin
               phase_in = PHASE_START;
               if (start_ff) begin
                  start_in = 1'b0;
                  if (detect && unit == BOM_NATIVE) begin
                     dropped = 1'b1;
                  end else if (detect && unit == BOM_SWAPPED) begin
                     dropped   = 1'b1;
                     little_in = 1'b1;
                  end
               end
               if (!dropped) begin
                  if (unit[15:10] == HIGH_SURR_TAG) begin
                     held_high_in = unit;
                     phase_in     = PHASE_HIGH;
                  end else begin
                     produce        = 1'b1;
                     res.first_unit = unit;
                     res.unit_count = 2'd1;
                  end
               end
            end
            PHASE_HIGH: begin
               held_byte_in = req_bus.data_byte;
               phase_in     = PHASE_HIGH_BYTE;
            end
            PHASE_HIGH_BYTE: begin
               produce  = 1'b1;
               phase_in = PHASE_START;
               if (unit[15:10] == LOW_SURR_TAG) begin
                  res.first_unit  = held_high_ff;
                  res.second_unit = unit;
                  res.unit_count  = 2'd2;
               end else begin
                  res.first_unit = REPLACEMENT;
                  res.unit_count = 2'd1;
                  res.status     = STATUS_NO_LOW;
               end
            end
            default: begin
               phase_in = PHASE_START;
            end
         endcase
         if (req_bus.last_byte) begin
            if (!produce) begin
               produce    = 1'b1;
               res.status = (phase_in != PHASE_START) ? STATUS_TRUNCATED : STATUS_OK;
            end
            phase_in = PHASE_START;
            start_in = 1'b1;
         end
         res.detected_little = little_in;
         res.end_of_run      = req_bus.last_byte;
      end
   end

   // result queue
   always_comb begin
      slot0_in = slot0_ff;
      slot1_in = slot1_ff;
      if (pop) begin
         slot0_in = slot1_ff;
      end
      wr_pos = count_ff - {1'b0, pop};
      if (accept && produce) begin
         if (wr_pos == 2'd0) begin
            slot0_in = res;
         end else begin
            slot1_in = res;
         end
      end
      count_in = count_ff - {1'b0, pop} + {1'b0, accept && produce};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff   <= MODE_DETECT;
         phase_ff  <= PHASE_START;
         little_ff <= 1'b0;
         start_ff  <= 1'b1;
         count_ff  <= 2'd0;
      end else begin
         if (csr_write_enable) begin
            mode_ff <= csr_write_data;
         end
         phase_ff  <= phase_in;
         little_ff <= little_in;
         start_ff  <= start_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      held_byte_ff <= held_byte_in;
      held_high_ff <= held_high_in;
      slot0_ff     <= slot0_in;
      slot1_ff     <= slot1_in;
   end

   assign rsp_bus.valid           = (count_ff != 2'd0);
   assign rsp_bus.first_unit      = slot0_ff.first_unit;
   assign rsp_bus.second_unit     = slot0_ff.second_unit;
   assign rsp_bus.unit_count      = slot0_ff.unit_count;
   assign rsp_bus.status          = slot0_ff.status;
   assign rsp_bus.detected_little = slot0_ff.detected_little;
   assign rsp_bus.end_of_run      = slot0_ff.end_of_run;

   // checks
   assert property (@(posedge clock) disable iff (reset)
      count_ff != 2'd3)
      else $error("result queue count out of range");

   assert property (@(posedge clock) disable iff (reset)
      rsp_bus.valid && rsp_bus.unit_count == 2'd0 |-> rsp_bus.end_of_run)
      else $error("empty result not at end of stream");

   assert property (@(posedge clock) disable iff (reset)
      rsp_bus.valid && rsp_bus.unit_count == 2'd2 |->
         rsp_bus.status == STATUS_OK && rsp_bus.first_unit[15:10] == HIGH_SURR_TAG &&
         rsp_bus.second_unit[15:10] == LOW_SURR_TAG)
      else $error("malformed surrogate pair");

   assert property (@(posedge clock) disable iff (reset)
      rsp_bus.valid && rsp_bus.status == STATUS_NO_LOW |->
         rsp_bus.first_unit == REPLACEMENT && rsp_bus.unit_count == 2'd1)
      else $error("missing low surrogate without replacement");

   assert property (@(posedge clock) disable iff (reset)
      accept && req_bus.last_byte |=> phase_ff == PHASE_START && start_ff)
      else $error("stream state not rearmed after last beat");

endmodule
